FILE: hw/rtl/owt_pkg.sv
`timescale 1ns / 1ps
package owt_pkg;

  localparam int MAX_CONNS  = 4;
  localparam int MAX_WINDOW = 8;
  localparam int MIN_LIMIT  = 5;
  localparam int MIN_TMO    = 5;

  localparam int SLOT_W = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
  localparam int WIN_W  = $clog2(MAX_WINDOW);
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W  = 6;
  localparam int LIM_W  = 4;
  localparam int TMO_W  = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_WINDOW_LIMIT = 2'd0;
  localparam logic [IDX_W-1:0] REG_TIMEOUT      = 2'd1;
  localparam logic [IDX_W-1:0] REG_NOTIFY       = 2'd2;

  typedef enum logic [1:0] {
    OP_ATTACH = 2'd0,
    OP_DETACH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_WFULL   = 3'd1,
    ST_NOENT   = 3'd2,
    ST_NOCONN  = 3'd3,
    ST_TFULL   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_ADV,
    S_LOOKUP,
    S_ATTACH,
    S_DETACH,
    S_FLUSH,
    S_TICK
  } state_t;

  typedef struct packed {
    logic    load_item;
    logic    tick_adv;
    logic    lookup;
    logic    attach_wr;
    logic    detach_drop;
    logic    flush_step;
    logic    flush_clear;
    logic    tick_drop;
    logic    next_slot;
    logic    emit_done;
    logic    emit_notice;
    logic    notice_tick;
    status_t status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic hit;
    logic free_ok;
    logic win_full;
    logic seq_hit;
    logic flush_more;
    logic tick_expire;
    logic last_slot;
    logic notify;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/owt_ctrl.sv
`timescale 1ns / 1ps
module owt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  owt_pkg::sts_t sts,
  output owt_pkg::cmd_t cmd
);
  import owt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.status = ST_OK;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        unique case (sts.op)
          OP_ATTACH: state_next = S_ATTACH;
          OP_DETACH: state_next = S_DETACH;
          OP_REMOVE: state_next = S_FLUSH;
          OP_TICK:   state_next = S_TICK_ADV;
          default:   state_next = S_IDLE;
        endcase
      end
      S_TICK_ADV: begin
        cmd.tick_adv = 1'b1;
        state_next   = S_TICK;
      end
      S_ATTACH: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_next    = S_IDLE;
          if (sts.hit && sts.win_full) begin
            cmd.status = ST_WFULL;
          end else if (!sts.hit && !sts.free_ok) begin
            cmd.status = ST_TFULL;
          end else begin
            cmd.attach_wr = 1'b1;
          end
        end
      end
      S_DETACH: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_next    = S_IDLE;
          if (!sts.hit) begin
            cmd.status = ST_NOCONN;
          end else if (sts.seq_hit) begin
            cmd.detach_drop = 1'b1;
          end else begin
            cmd.status = ST_NOENT;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.hit) begin
          if (sts.out_free) begin
            cmd.emit_done = 1'b1;
            cmd.status    = ST_NOCONN;
            state_next    = S_IDLE;
          end
        end else if (sts.flush_more) begin
          if (!sts.notify) begin
            cmd.flush_step = 1'b1;
          end else if (sts.out_free) begin
            cmd.flush_step  = 1'b1;
            cmd.emit_notice = 1'b1;
          end
        end else if (sts.out_free) begin
          cmd.flush_clear = 1'b1;
          cmd.emit_done   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_TICK: begin
        if (sts.tick_expire) begin
          if (!sts.notify) begin
            cmd.tick_drop = 1'b1;
          end else if (sts.out_free) begin
            cmd.tick_drop   = 1'b1;
            cmd.emit_notice = 1'b1;
            cmd.notice_tick = 1'b1;
          end
        end else if (!sts.last_slot) begin
          cmd.next_slot = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/owt_dpath.sv
`timescale 1ns / 1ps
module owt_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [owt_pkg::IDX_W-1:0]  cfg_index,
  input  logic [owt_pkg::CFG_W-1:0]  cfg_data,
  input  logic [1:0]                 in_op,
  input  logic [31:0]                in_obj,
  input  logic [31:0]                in_seq,
  input  owt_pkg::cmd_t              cmd,
  output owt_pkg::sts_t              sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_kind,
  output logic [2:0]                 out_status,
  output logic [owt_pkg::CNT_W-1:0]  out_count,
  output logic [31:0]                out_obj,
  output logic [31:0]                out_seq,
  output logic                       out_last
);
  import owt_pkg::*;

  logic [LIM_W-1:0]  limit;
  logic [TMO_W-1:0]  tmo;
  logic              notify;

  logic [31:0]       ids   [MAX_CONNS];
  logic              in_use[MAX_CONNS];
  logic [FILL_W-1:0] fill  [MAX_CONNS];
  logic [31:0]       seqs  [MAX_CONNS][MAX_WINDOW];
  logic [31:0]       times [MAX_CONNS][MAX_WINDOW];
  logic [31:0]       now;

  op_t               op;
  logic [31:0]       obj;
  logic [31:0]       seq;
  logic [SLOT_W-1:0] sc;
  logic [FILL_W-1:0] ic;
  logic              hit;
  logic              free_ok;
  logic [CNT_W-1:0]  cnt;

  logic [SLOT_W-1:0] hit_s, free_s;
  logic              hit_any, free_any;
  logic [WIN_W-1:0]  seq_k, drop_pos;
  logic              seq_any;
  logic [31:0]       age;
  logic              out_free;
  logic [LIM_W-1:0]  lim_in;
  logic [TMO_W-1:0]  tmo_in;

  always_comb begin
    hit_s    = '0;
    hit_any  = 1'b0;
    free_s   = '0;
    free_any = 1'b0;
    for (int s = MAX_CONNS - 1; s >= 0; s--) begin
      if (in_use[s] && ids[s] == obj) begin
        hit_any = 1'b1;
        hit_s   = SLOT_W'(s);
      end
      if (!in_use[s]) begin
        free_any = 1'b1;
        free_s   = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    seq_k   = '0;
    seq_any = 1'b0;
    for (int k = MAX_WINDOW - 1; k >= 0; k--) begin
      if (FILL_W'(k) < fill[sc] && seqs[sc][k] == seq) begin
        seq_any = 1'b1;
        seq_k   = WIN_W'(k);
      end
    end
  end

  assign age      = now - times[sc][0];
  assign drop_pos = cmd.detach_drop ? seq_k : '0;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts.op          = op;
    sts.hit         = hit;
    sts.free_ok     = free_ok;
    sts.win_full    = fill[sc] >= limit;
    sts.seq_hit     = seq_any;
    sts.flush_more  = ic < fill[sc];
    sts.tick_expire = in_use[sc] && fill[sc] != '0 && age >= {16'd0, tmo};
    sts.last_slot   = sc == SLOT_W'(MAX_CONNS - 1);
    sts.notify      = notify;
    sts.out_free    = out_free;
  end

  always_comb begin
    lim_in = cfg_data[LIM_W-1:0];
    if (lim_in < LIM_W'(MIN_LIMIT)) lim_in = LIM_W'(MIN_LIMIT);
    if (lim_in > LIM_W'(MAX_WINDOW)) lim_in = LIM_W'(MAX_WINDOW);
    tmo_in = cfg_data[TMO_W-1:0];
    if (tmo_in < TMO_W'(MIN_TMO)) tmo_in = TMO_W'(MIN_TMO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= LIM_W'(MIN_LIMIT);
      tmo    <= TMO_W'(MIN_TMO);
      notify <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LIMIT: limit  <= lim_in;
        REG_TIMEOUT:      tmo    <= tmo_in;
        REG_NOTIFY:       notify <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op  <= op_t'(in_op);
      obj <= in_obj;
      seq <= in_seq;
    end
    if (cmd.lookup) begin
      hit     <= hit_any;
      free_ok <= free_any;
      sc      <= hit_any ? hit_s : free_s;
      ic      <= '0;
    end
    if (cmd.tick_adv) sc <= '0;
    if (cmd.next_slot) sc <= sc + 1'b1;
    if (cmd.flush_step) ic <= ic + 1'b1;
    if (cmd.attach_wr) begin
      ids[sc]                      <= obj;
      seqs[sc][fill[sc][WIN_W-1:0]]  <= seq;
      times[sc][fill[sc][WIN_W-1:0]] <= now;
    end
    if (cmd.detach_drop || cmd.tick_drop) begin
      for (int i = 0; i < MAX_WINDOW - 1; i++) begin
        if (WIN_W'(i) >= drop_pos) begin
          seqs[sc][i]  <= seqs[sc][i+1];
          times[sc][i] <= times[sc][i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
      cnt <= '0;
      for (int s = 0; s < MAX_CONNS; s++) begin
        in_use[s] <= 1'b0;
        fill[s]   <= '0;
      end
    end else begin
      if (cmd.load_item) cnt <= '0;
      if (cmd.tick_adv) now <= now + 32'd1;
      if (cmd.attach_wr) begin
        in_use[sc] <= 1'b1;
        fill[sc]   <= fill[sc] + 1'b1;
      end
      if (cmd.detach_drop || cmd.tick_drop) fill[sc] <= fill[sc] - 1'b1;
      if (cmd.flush_step || cmd.tick_drop) cnt <= cnt + 1'b1;
      if (cmd.flush_clear) begin
        in_use[sc] <= 1'b0;
        fill[sc]   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_done || cmd.emit_notice) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_done) begin
      out_kind   <= 1'b0;
      out_status <= cmd.status;
      out_count  <= cnt;
      out_obj    <= '0;
      out_seq    <= '0;
      out_last   <= 1'b1;
    end else if (cmd.emit_notice) begin
      out_kind   <= 1'b1;
      out_status <= ST_OK;
      out_count  <= '0;
      out_obj    <= cmd.notice_tick ? ids[sc] : obj;
      out_seq    <= cmd.notice_tick ? seqs[sc][0] : seqs[sc][ic[WIN_W-1:0]];
      out_last   <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/outstanding_window_tracker.sv
`timescale 1ns / 1ps
// Channel   | Dir | Handshake               | Payload
// s_axis    | in  | s_tvalid / s_tready     | s_tuser operation, s_tdata ids
// m_axis    | out | m_tvalid / m_tready     | m_tuser kind, m_tlast, m_tdata
// cfg       | in  | cfg_we                  | cfg_index, cfg_data
//
// One item at a time; input is taken only in the idle state.
// Remove steps through each window entry; tick scans all slots and drops expired entries.
// The single output register sets the pace of notices when m_tready stalls.
// rst is synchronous; it clears the slot table and the clock and resets configuration to defaults.
module outstanding_window_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [owt_pkg::IDX_W-1:0]         cfg_index,
  input  logic [owt_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [1:0]                        s_tuser,  // operation
  input  logic [63:0]                       s_tdata,  // object_id, seq_no
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic                              m_tuser,  // kind
  output logic                              m_tlast,
  output logic [79:0]                       m_tdata   // status, count, entry_object, entry_seq
);
  import owt_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [2:0]       status;
  logic [CNT_W-1:0] count;
  logic [31:0]      eobj, eseq;

  owt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  owt_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_op      (s_tuser),
    .in_obj     (s_tdata[31:0]),
    .in_seq     (s_tdata[63:32]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_status (status),
    .out_count  (count),
    .out_obj    (eobj),
    .out_seq    (eseq),
    .out_last   (m_tlast)
  );

  assign m_tdata = {7'd0, eseq, eobj, count, status};

endmodule
